>>> rtl/triangle_tangent_frame_macros.svh
// Assertion macros for the triangle tangent frame checker.
// Needs a signal named clk and an active-low rst_n in the using scope.
`ifndef TRIANGLE_TANGENT_FRAME_MACROS_SVH
`define TRIANGLE_TANGENT_FRAME_MACROS_SVH

// same-cycle implication, off during reset
`define TTF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttf assertion failed");

// next-cycle implication, off during reset
`define TTF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttf assertion failed");

// next-cycle implication, checked in reset as well
`define TTF_ASSERT_NEXT_ALL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ttf assertion failed");

`endif

>>> rtl/ttf_pkg.sv
// Shared types for the triangle tangent frame block.
// No dependencies.
package ttf_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
  } vtx_in_t;

  typedef struct packed {
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic signed [15:0] bitangent_x;
    logic signed [15:0] bitangent_y;
    logic signed [15:0] bitangent_z;
    logic               degenerate;
  } frame_out_t;

  localparam int unsigned OP_W   = 33;  // signed delta width
  localparam int unsigned PROD_W = 66;

endpackage

>>> rtl/ttf_mul.sv
// Shared registered signed multiplier for the tangent frame sequencer.
// Depends on ttf_pkg.
module ttf_mul (
  input  logic                                   clk,
  input  logic signed [ttf_pkg::OP_W-1:0]        a,
  input  logic signed [ttf_pkg::OP_W-1:0]        b,
  output logic signed [ttf_pkg::PROD_W-1:0]      p_r
);
  import ttf_pkg::*;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

>>> rtl/triangle_tangent_frame.sv
// Triangle tangent frame: the first two vertices of a triangle are stored on transfer.
// The third vertex starts 14 products for the determinant and the two frame vectors, then per
// vector a load, normalising shifts, three squares, a bit-serial square root and three divides,
// all on one shared multiplier; the sequence ends early with a degenerate result when the
// determinant or a frame vector is zero.
// rst_n is synchronous: clears the vertex count, sequencer and output valid.
module triangle_tangent_frame (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ttf_pkg::vtx_in_t     in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ttf_pkg::frame_out_t  out_data
);
  import ttf_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL   = 4'd1;
  localparam logic [3:0] ST_ACC   = 4'd2;
  localparam logic [3:0] ST_NLOAD = 4'd3;
  localparam logic [3:0] ST_NSH   = 4'd4;
  localparam logic [3:0] ST_SQ    = 4'd5;
  localparam logic [3:0] ST_SQA   = 4'd6;
  localparam logic [3:0] ST_SQRT  = 4'd7;
  localparam logic [3:0] ST_DLOAD = 4'd8;
  localparam logic [3:0] ST_DIV   = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  logic [3:0]               state_r;
  logic [1:0]               cnt_r;
  logic signed [31:0]       hp_r [6];
  logic signed [31:0]       ht_r [4];
  logic signed [32:0]       e1_r [3];
  logic signed [32:0]       e2_r [3];
  logic signed [32:0]       du1_r, dv1_r, du2_r, dv2_r;
  logic [3:0]               j_r;
  logic signed [66:0]       acc_r;
  logic signed [66:0]       vec_r [7];
  logic                     vsel_r;
  logic [66:0]              mag_r [3];
  logic [2:0]               sg_r;
  logic [1:0]               k_r;
  logic [63:0]              sum_r;
  logic [63:0]              rem_r;
  logic [63:0]              root_r;
  logic [4:0]               i_r;
  logic [49:0]              drem_r;
  logic [16:0]              q_r;
  logic [4:0]               di_r;
  logic [15:0]              code_r [6];
  logic                     degen_r;
  logic                     out_valid_r;
  frame_out_t               out_data_r;

  logic signed [OP_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic [2:0]               ridx;
  logic [1:0]               rk;
  logic signed [66:0]       prod_x, diff, diff_fix;
  logic [66:0]              mor;
  logic [63:0]              sq_bit, sq_try;
  logic [49:0]              dsh;
  logic                     dfit;
  logic [16:0]              q_fin;
  logic [15:0]              code_v;
  logic [2:0]               vbase;
  logic                     take_in, out_free;

  ttf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(prod_r));

  assign in_ready  = (state_r == ST_IDLE);
  assign take_in   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  assign ridx = j_r[3:1];
  assign rk   = (ridx >= 3'd4) ? 2'(ridx - 3'd4) : 2'(ridx - 3'd1);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_SQ) begin
      mul_a = {2'b00, mag_r[k_r][30:0]};
      mul_b = {2'b00, mag_r[k_r][30:0]};
    end else if (ridx == 3'd0) begin
      mul_a = j_r[0] ? dv1_r : du1_r;
      mul_b = j_r[0] ? du2_r : dv2_r;
    end else if (ridx <= 3'd3) begin
      mul_a = j_r[0] ? e2_r[rk] : e1_r[rk];
      mul_b = j_r[0] ? dv1_r : dv2_r;
    end else begin
      mul_a = j_r[0] ? e1_r[rk] : e2_r[rk];
      mul_b = j_r[0] ? du2_r : du1_r;
    end
  end

  always_comb begin
    prod_x   = {prod_r[PROD_W-1], prod_r};
    diff     = acc_r - prod_x;
    // flip by the determinant's sign once it is known
    diff_fix = (ridx != 3'd0 && vec_r[0] < 0) ? -diff : diff;
    mor      = mag_r[0] | mag_r[1] | mag_r[2];
    sq_bit   = 64'd1 << {i_r, 1'b0};
    sq_try   = root_r + sq_bit;
    dsh      = {16'd0, root_r[31:0], 1'b0} << di_r;
    dfit     = (drem_r >= dsh);
    q_fin    = q_r | (dfit ? (17'd1 << di_r) : 17'd0);
    if (sg_r[k_r]) code_v = 16'(17'd0 - q_fin);
    else if (q_fin > 17'd32767) code_v = 16'd32767;
    else code_v = q_fin[15:0];
    vbase    = vsel_r ? 3'd4 : 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != ST_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (take_in) begin
            if (cnt_r != 2'd2) begin
              if (cnt_r[0]) begin
                hp_r[3] <= in_data.pos_x;
                hp_r[4] <= in_data.pos_y;
                hp_r[5] <= in_data.pos_z;
                ht_r[2] <= in_data.tex_u;
                ht_r[3] <= in_data.tex_v;
              end else begin
                hp_r[0] <= in_data.pos_x;
                hp_r[1] <= in_data.pos_y;
                hp_r[2] <= in_data.pos_z;
                ht_r[0] <= in_data.tex_u;
                ht_r[1] <= in_data.tex_v;
              end
              cnt_r <= cnt_r + 2'd1;
            end else begin
              for (int k = 0; k < 3; k++) begin
                e1_r[k] <= 33'(hp_r[3+k]) - 33'(hp_r[k]);
              end
              e2_r[0] <= 33'(in_data.pos_x) - 33'(hp_r[0]);
              e2_r[1] <= 33'(in_data.pos_y) - 33'(hp_r[1]);
              e2_r[2] <= 33'(in_data.pos_z) - 33'(hp_r[2]);
              du1_r   <= 33'(ht_r[2]) - 33'(ht_r[0]);
              dv1_r   <= 33'(ht_r[3]) - 33'(ht_r[1]);
              du2_r   <= 33'(in_data.tex_u) - 33'(ht_r[0]);
              dv2_r   <= 33'(in_data.tex_v) - 33'(ht_r[1]);
              cnt_r   <= '0;
              j_r     <= '0;
              degen_r <= 1'b0;
              state_r <= ST_MUL;
            end
          end
        end
        ST_MUL: state_r <= ST_ACC;
        ST_ACC: begin
          if (!j_r[0]) begin
            acc_r <= prod_x;
            state_r <= ST_MUL;
          end else begin
            vec_r[ridx] <= diff_fix;
            if (j_r == 4'd13) begin
              vsel_r <= 1'b0;
              if (vec_r[0] == 0) begin
                degen_r <= 1'b1;
                state_r <= ST_OUT;
              end else begin
                state_r <= ST_NLOAD;
              end
            end else begin
              state_r <= ST_MUL;
            end
          end
          j_r <= j_r + 4'd1;
        end
        ST_NLOAD: begin
          for (int k = 0; k < 3; k++) begin
            mag_r[k] <= (vec_r[vbase + 3'(k)] < 0) ? 67'(-vec_r[vbase + 3'(k)])
                                                   : 67'(vec_r[vbase + 3'(k)]);
            sg_r[k]  <= (vec_r[vbase + 3'(k)] < 0);
          end
          if (vec_r[vbase] == 0 && vec_r[vbase + 3'd1] == 0 && vec_r[vbase + 3'd2] == 0)
          begin
            degen_r <= 1'b1;
            state_r <= ST_OUT;
          end else begin
            state_r <= ST_NSH;
          end
        end
        ST_NSH: begin
          // bring the largest magnitude into [2^30, 2^31); right shifts truncate
          for (int k = 0; k < 3; k++) begin
            if (mor[66:35] != 0)      mag_r[k] <= mag_r[k] >> 4;
            else if (mor[34:31] != 0) mag_r[k] <= mag_r[k] >> 1;
            else if (mor[30:26] == 0) mag_r[k] <= mag_r[k] << 4;
            else if (!mor[30])        mag_r[k] <= mag_r[k] << 1;
          end
          if (mor[66:31] == 0 && mor[30]) begin
            k_r     <= '0;
            sum_r   <= '0;
            state_r <= ST_SQ;
          end
        end
        ST_SQ: state_r <= ST_SQA;
        ST_SQA: begin
          if (k_r == 2'd2) begin
            rem_r   <= sum_r + prod_r[63:0];
            root_r  <= '0;
            i_r     <= 5'd31;
            state_r <= ST_SQRT;
            k_r     <= '0;
          end else begin
            sum_r   <= sum_r + prod_r[63:0];
            k_r     <= k_r + 2'd1;
            state_r <= ST_SQ;
          end
        end
        ST_SQRT: begin
          if (rem_r >= sq_try) begin
            rem_r  <= rem_r - sq_try;
            root_r <= (root_r >> 1) + sq_bit;
          end else begin
            root_r <= root_r >> 1;
          end
          i_r <= i_r - 5'd1;
          if (i_r == 5'd0) state_r <= ST_DLOAD;
        end
        ST_DLOAD: begin
          drem_r  <= {3'd0, mag_r[k_r][30:0], 16'd0} + {18'd0, root_r[31:0]};
          q_r     <= '0;
          di_r    <= 5'd16;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (dfit) drem_r <= drem_r - dsh;
          q_r  <= q_fin;
          di_r <= di_r - 5'd1;
          if (di_r == 5'd0) begin
            code_r[{1'b0, k_r} + (vsel_r ? 3'd3 : 3'd0)] <= code_v;
            if (k_r == 2'd2) begin
              if (vsel_r) begin
                state_r <= ST_OUT;
              end else begin
                vsel_r  <= 1'b1;
                state_r <= ST_NLOAD;
              end
            end else begin
              k_r     <= k_r + 2'd1;
              state_r <= ST_DLOAD;
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // result register, loaded with the transfer slot free
  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_data_r.tangent_x   <= degen_r ? '0 : code_r[0];
      out_data_r.tangent_y   <= degen_r ? '0 : code_r[1];
      out_data_r.tangent_z   <= degen_r ? '0 : code_r[2];
      out_data_r.bitangent_x <= degen_r ? '0 : code_r[3];
      out_data_r.bitangent_y <= degen_r ? '0 : code_r[4];
      out_data_r.bitangent_z <= degen_r ? '0 : code_r[5];
      out_data_r.degenerate  <= degen_r;
    end
  end

endmodule

>>> rtl/ttf_checker.sv
// Port-level checks for triangle_tangent_frame, bound to the top level.
// Depends on ttf_pkg and triangle_tangent_frame_macros.svh.
`include "triangle_tangent_frame_macros.svh"

module ttf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input ttf_pkg::vtx_in_t    in_data,
  input logic                out_valid,
  input logic                out_ready,
  input ttf_pkg::frame_out_t out_data
);
  import ttf_pkg::*;

  logic tan_zero, bit_zero;

  assign tan_zero = (out_data.tangent_x == 0) && (out_data.tangent_y == 0) &&
                    (out_data.tangent_z == 0);
  assign bit_zero = (out_data.bitangent_x == 0) && (out_data.bitangent_y == 0) &&
                    (out_data.bitangent_z == 0);

  `TTF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `TTF_ASSERT_NEXT_ALL(a_rst_quiet, !rst_n, !out_valid)
  `TTF_ASSERT_IMPL(a_degen_zero, out_valid && out_data.degenerate, tan_zero && bit_zero)
  `TTF_ASSERT_IMPL(a_unit_nonzero, out_valid && !out_data.degenerate, !tan_zero && !bit_zero)

endmodule

bind triangle_tangent_frame ttf_checker u_ttf_checker (.*);
